@@ src/bcei_pkg.sv @@
// ----------------------------------------------------------------------------
// bcei_pkg
// Shared types, register map, widths and the sensor classifier for the
// blink code error indicator.
// ----------------------------------------------------------------------------
package bcei_pkg;

  localparam int TICK_W     = 20;
  localparam int ALT_W      = 8;
  localparam int HALF_W     = 16;
  localparam int CODE_W     = 3;
  localparam int TIDX_W     = 4;
  localparam int LIMIT_US_W = 26;  // 65535 ms in microseconds fits 26 bits
  localparam int SUM_W      = LIMIT_US_W + 1;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [LIMIT_US_W-1:0] US_PER_MS = LIMIT_US_W'(1000);

  localparam logic [TICK_W-1:0] TICK_PERIOD_RST = TICK_W'(1000);
  localparam logic [ALT_W-1:0]  ALT_LIMIT_RST   = ALT_W'(100);
  localparam logic [HALF_W-1:0] PAUSE_HALF_RST  = HALF_W'(3000);
  localparam logic [HALF_W-1:0] CODE_HALF_RST   = HALF_W'(500);

  localparam logic [TIDX_W-1:0] PAUSE_TOGGLES = TIDX_W'(2);

  // Error codes, in priority order
  localparam logic [CODE_W-1:0] CODE_NONE         = 3'd0;
  localparam logic [CODE_W-1:0] CODE_NO_CASSETTE  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_TWO_CASSETTE = 3'd2;
  localparam logic [CODE_W-1:0] CODE_TABLE_FRONT  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_TABLE_HIGH   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_TABLE_LOW    = 3'd5;
  localparam logic [CODE_W-1:0] CODE_TABLE_LOST   = 3'd6;
  localparam logic [CODE_W-1:0] CODE_MAX          = CODE_TABLE_LOST;

  typedef enum logic [1:0] {
    REG_TICK_PERIOD = 2'd0,
    REG_ALT_LIMIT   = 2'd1,
    REG_PAUSE_HALF  = 2'd2,
    REG_CODE_HALF   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic cassette_lower;
    logic cassette_upper;
    logic table_back_low;
    logic table_back_high;
    logic table_front_pos;
  } in_t;

  typedef struct packed {
    logic              changing_led;
    logic              table_led;
    logic              status_led;
    logic [CODE_W-1:0] fault_code;
  } out_t;

  // Timing setup handed to the status blink engine
  typedef struct packed {
    logic [TICK_W-1:0]     tick_period_us;
    logic [LIMIT_US_W-1:0] pause_limit_us;
    logic [LIMIT_US_W-1:0] code_limit_us;
  } timing_t;

  // Status result after one tick
  typedef struct packed {
    logic              status_led;
    logic [CODE_W-1:0] fault_code;
  } status_t;

  function automatic logic [CODE_W-1:0] classify(input in_t s);
    logic [CODE_W-1:0] c;
    c = CODE_NONE;
    if (!s.cassette_lower && !s.cassette_upper) begin
      c = CODE_NO_CASSETTE;
    end else if (s.cassette_lower && s.cassette_upper) begin
      c = CODE_TWO_CASSETTE;
    end else if (!s.table_back_low && !s.table_back_high && s.table_front_pos) begin
      c = CODE_TABLE_FRONT;
    end else if (s.table_back_high && !s.table_back_low && !s.table_front_pos) begin
      c = CODE_TABLE_HIGH;
    end else if (s.table_back_low && !s.table_back_high && !s.table_front_pos) begin
      c = CODE_TABLE_LOW;
    end else if (!s.table_back_low && !s.table_back_high && !s.table_front_pos) begin
      c = CODE_TABLE_LOST;
    end
    return c;
  endfunction

  function automatic logic [LIMIT_US_W-1:0] half_to_us(input logic [HALF_W-1:0] ms);
    return LIMIT_US_W'(ms) * US_PER_MS;
  endfunction

endpackage

@@ src/blink_code_error_indicator.sv @@
// ----------------------------------------------------------------------------
// blink_code_error_indicator
// Top level: sensor classification, alternating indicators, status blink
// code, output register and register file.
// ----------------------------------------------------------------------------
// Each input transfer is one tick of five sensor bits and yields exactly one
// result transfer in the next cycle with the indicator levels, the status LED
// level and the classified error code after that tick. A tick can be taken
// every cycle the sink does not stall: the only storage on the path is the
// single output register, refilled in the same cycle it is drained. Interval
// registers are converted to microseconds when written, so a tick costs one
// add and one compare. Write registers only while no tick is in flight.
module blink_code_error_indicator
  import bcei_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,

  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [TICK_W-1:0]     tick_period_r;
  logic [ALT_W-1:0]      alt_limit_r;
  logic [HALF_W-1:0]     pause_half_r;
  logic [HALF_W-1:0]     code_half_r;
  logic [LIMIT_US_W-1:0] pause_limit_r;
  logic [LIMIT_US_W-1:0] code_limit_r;

  logic [ALT_W-1:0]      alt_counter_r, alt_counter_nxt;
  logic                  alt_phase_r, alt_phase_nxt;
  logic                  alt_started_r, alt_started_nxt;

  logic                  out_valid_r;
  out_t                  out_data_r;

  logic                  accept;
  logic                  wr_en;
  reg_idx_t              reg_idx;
  timing_t               timing;
  status_t               status_nxt;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
      alt_limit_r   <= ALT_LIMIT_RST;
      pause_half_r  <= PAUSE_HALF_RST;
      code_half_r   <= CODE_HALF_RST;
      pause_limit_r <= half_to_us(PAUSE_HALF_RST);
      code_limit_r  <= half_to_us(CODE_HALF_RST);
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK_PERIOD: tick_period_r <= pwdata[TICK_W-1:0];
        REG_ALT_LIMIT:   alt_limit_r   <= pwdata[ALT_W-1:0];
        REG_PAUSE_HALF: begin
          pause_half_r  <= pwdata[HALF_W-1:0];
          pause_limit_r <= half_to_us(pwdata[HALF_W-1:0]);
        end
        REG_CODE_HALF: begin
          code_half_r  <= pwdata[HALF_W-1:0];
          code_limit_r <= half_to_us(pwdata[HALF_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TICK_PERIOD: prdata = DATA_W'(tick_period_r);
      REG_ALT_LIMIT:   prdata = DATA_W'(alt_limit_r);
      REG_PAUSE_HALF:  prdata = DATA_W'(pause_half_r);
      REG_CODE_HALF:   prdata = DATA_W'(code_half_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  // hold the input only while a result waits and the sink stalls
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- alternating indicators ----------------
  always_comb begin
    alt_counter_nxt = alt_counter_r;
    alt_phase_nxt   = alt_phase_r;
    alt_started_nxt = alt_started_r;
    if (alt_counter_r < alt_limit_r) begin
      alt_counter_nxt = alt_counter_r + ALT_W'(1);
    end else begin
      alt_counter_nxt = '0;
      alt_phase_nxt   = ~alt_phase_r;
      alt_started_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_counter_r <= '0;
      alt_phase_r   <= 1'b0;
      alt_started_r <= 1'b0;
    end else if (accept) begin
      alt_counter_r <= alt_counter_nxt;
      alt_phase_r   <= alt_phase_nxt;
      alt_started_r <= alt_started_nxt;
    end
  end

  // ---------------- status blink code ----------------
  assign timing.tick_period_us = tick_period_r;
  assign timing.pause_limit_us = pause_limit_r;
  assign timing.code_limit_us  = code_limit_r;

  bcei_blink u_blink (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .code       (classify(in_data)),
    .timing     (timing),
    .status_nxt (status_nxt)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.changing_led <= alt_phase_nxt;
      out_data_r.table_led    <= alt_started_nxt && !alt_phase_nxt;
      out_data_r.status_led   <= status_nxt.status_led;
      out_data_r.fault_code   <= status_nxt.fault_code;
    end
  end

  // ---------------- assertions ----------------
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no result");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fault_code <= CODE_MAX))
    else $error("error code out of range");

  a_indicators_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_led) |-> !out_data.changing_led)
    else $error("both indicator LEDs lit");

  a_no_code_led_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.fault_code == CODE_NONE)) |-> !out_data.status_led)
    else $error("status LED lit with no error code");

endmodule

@@ src/bcei_blink.sv @@
// ----------------------------------------------------------------------------
// bcei_blink
// Status LED blink code engine: pause toggles, then two toggles per code
// unit, restarted whenever the classified code changes.
// ----------------------------------------------------------------------------
module bcei_blink
  import bcei_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CODE_W-1:0] code,
  input  timing_t           timing,
  output status_t           status_nxt
);

  logic [CODE_W-1:0]     code_now_r, code_now_nxt;
  logic                  phase_sel_r, phase_sel_nxt;
  logic [TIDX_W-1:0]     toggle_idx_r, toggle_idx_nxt;
  logic [LIMIT_US_W-1:0] elapsed_r, elapsed_nxt;
  logic                  level_r, level_nxt;

  logic [SUM_W-1:0]      elapsed_sum;
  logic [LIMIT_US_W-1:0] limit_us;
  logic [TIDX_W-1:0]     toggle_inc;
  logic [TIDX_W-1:0]     toggle_count;

  assign elapsed_sum  = SUM_W'(elapsed_r) + SUM_W'(timing.tick_period_us);
  assign limit_us     = phase_sel_r ? timing.code_limit_us : timing.pause_limit_us;
  assign toggle_inc   = toggle_idx_r + TIDX_W'(1);
  assign toggle_count = phase_sel_r ? {1'b0, code_now_r} << 1 : PAUSE_TOGGLES;

  always_comb begin
    code_now_nxt   = code_now_r;
    phase_sel_nxt  = phase_sel_r;
    toggle_idx_nxt = toggle_idx_r;
    elapsed_nxt    = elapsed_r;
    level_nxt      = level_r;
    if (code != code_now_r) begin
      // restart the pattern, no time accumulated on this tick
      code_now_nxt   = code;
      phase_sel_nxt  = 1'b0;
      toggle_idx_nxt = '0;
      elapsed_nxt    = '0;
      level_nxt      = 1'b0;
    end else if (code_now_r != CODE_NONE) begin
      if (elapsed_sum < SUM_W'(limit_us)) begin
        elapsed_nxt = elapsed_sum[LIMIT_US_W-1:0];
      end else begin
        elapsed_nxt = '0;
        level_nxt   = ~level_r;
        if (toggle_inc >= toggle_count) begin
          toggle_idx_nxt = '0;
          phase_sel_nxt  = ~phase_sel_r;
        end else begin
          toggle_idx_nxt = toggle_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_now_r   <= CODE_NONE;
      phase_sel_r  <= 1'b0;
      toggle_idx_r <= '0;
      elapsed_r    <= '0;
      level_r      <= 1'b0;
    end else if (step) begin
      code_now_r   <= code_now_nxt;
      phase_sel_r  <= phase_sel_nxt;
      toggle_idx_r <= toggle_idx_nxt;
      elapsed_r    <= elapsed_nxt;
      level_r      <= level_nxt;
    end
  end

  assign status_nxt.status_led = level_nxt;
  assign status_nxt.fault_code = code_now_nxt;

endmodule
